[hdl/itoa_fmt_pkg.sv]
// Package with the types, constants and control store of the integer to ASCII formatter.
package itoa_fmt_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned COUNT_W       = 31;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  // Digit glyphs
  localparam logic [CHAR_W-1:0] HEX_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };
  localparam logic [CHAR_W-1:0] HEX_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEXL = 2'd2,
    MODE_HEXU = 2'd3
  } mode_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [MODE_W-1:0]  mode;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               last_char;
    logic [COUNT_W-1:0] total_chars;
  } out_t;

  // Microcode
  typedef logic [2:0] step_t;

  localparam step_t ST_LOAD   = 3'd0;
  localparam step_t ST_DABBLE = 3'd1;
  localparam step_t ST_SKIP   = 3'd2;
  localparam step_t ST_SIGN   = 3'd3;
  localparam step_t ST_EMIT   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_LOOP,
    C_HEX,
    C_LEAD_ZERO,
    C_SIGN_WAIT,
    C_EMIT_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e hold;    // stay on this step while true
    cond_e jump;    // otherwise branch to target while true
    step_t target;
  } ctrl_t;

  // Status flags tested by the sequencer
  typedef struct packed {
    logic no_input;
    logic loop;
    logic hex;
    logic lead_zero;
    logic sign_wait;
    logic emit_more;
  } flags_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    case (pc)
      ST_LOAD:   w = '{op: OP_LOAD,   hold: C_NO_INPUT,  jump: C_HEX,    target: ST_SKIP};
      ST_DABBLE: w = '{op: OP_DABBLE, hold: C_LOOP,      jump: C_NEVER,  target: ST_LOAD};
      ST_SKIP:   w = '{op: OP_SKIP,   hold: C_LEAD_ZERO, jump: C_NEVER,  target: ST_LOAD};
      ST_SIGN:   w = '{op: OP_SIGN,   hold: C_SIGN_WAIT, jump: C_NEVER,  target: ST_LOAD};
      ST_EMIT:   w = '{op: OP_EMIT,   hold: C_EMIT_MORE, jump: C_ALWAYS, target: ST_LOAD};
      default:   w = '{op: OP_NOP,    hold: C_NEVER,     jump: C_ALWAYS, target: ST_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic cond_true(cond_e c, flags_t f);
    logic r;
    case (c)
      C_NEVER:     r = 1'b0;
      C_ALWAYS:    r = 1'b1;
      C_NO_INPUT:  r = f.no_input;
      C_LOOP:      r = f.loop;
      C_HEX:       r = f.hex;
      C_LEAD_ZERO: r = f.lead_zero;
      C_SIGN_WAIT: r = f.sign_wait;
      C_EMIT_MORE: r = f.emit_more;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] c;
    c = upper ? HEX_UPPER[d] : HEX_LOWER[d];
    return c;
  endfunction

endpackage

[hdl/integer_to_ascii_formatter_top.sv]
// Top level of the integer to ASCII formatter: microcoded sequencer and its datapath.
//
// Usage: one input transaction carries a value and a format mode (signed decimal, unsigned
// decimal, lowercase hex, uppercase hex). The block returns the ASCII characters of the
// number, most significant first, one output transaction per character, with no leading
// zeros, a single '0' for zero and a leading '-' for negative signed values. Each character
// carries last_char on the final one of its run and a saturating count of all characters
// sent since reset.
// Sequence: the sequencer first loads the operand; decimal modes then run the binary-to-BCD
// loop (four bits per cycle), while hex modes go straight to the skip step. The skip step
// drops each leading zero out of NDIG digit slots (11 at the default width) and then moves
// on, the sign step sends a '-' only for a negative signed value, and the emit step sends
// the characters. The skip over the fixed digit slots makes the time independent of the
// number: with the output always ready it depends only on the mode and VALUE_WIDTH,
// counted from one accepting edge to the next.
// A new input is taken while the last character still waits in the output register.
// A stall on the output holds the sequencer on the sign or emit step; nothing is dropped.
// Reset returns the sequencer to the load step, empties the output register and clears
// the character count.
module integer_to_ascii_formatter_top #(
  parameter int unsigned VALUE_WIDTH = itoa_fmt_pkg::DEF_VALUE_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  itoa_fmt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output itoa_fmt_pkg::out_t out_data_o
);

  // Derived sizes
  localparam int unsigned DAB_STEPS = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned MW        = 4 * DAB_STEPS;
  localparam int unsigned ND        = (VALUE_WIDTH * 3) / 10 + 2;
  localparam int unsigned NDIG      = (ND > DAB_STEPS) ? ND : DAB_STEPS;
  localparam int unsigned DR_W      = 4 * NDIG;
  localparam int unsigned RW        = $clog2(NDIG + 1);
  localparam int unsigned CW        = (DAB_STEPS > 1) ? $clog2(DAB_STEPS) : 1;
  localparam logic [MW-1:0] MASK    = {MW{1'b1}} >> (MW - VALUE_WIDTH);

  itoa_fmt_pkg::step_t  pc_q, pc_d;
  itoa_fmt_pkg::ctrl_t  ctrl;
  itoa_fmt_pkg::flags_t flags;

  logic [MW-1:0]   mag_q, mag_d;
  logic [DR_W-1:0] dr_q, dr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic            neg_q, neg_d;
  logic            hex_q, hex_d;
  logic            upper_q, upper_d;

  logic                       out_valid_q, out_valid_d;
  itoa_fmt_pkg::out_t         out_q, out_d;
  logic [itoa_fmt_pkg::COUNT_W-1:0] char_total_q, char_total_d;

  logic            in_fire;
  logic            blocked;
  logic [MW-1:0]   operand;
  logic            in_neg;
  logic            in_hex;
  logic [3:0]      top_digit;
  logic            last_digit;
  logic [DR_W-1:0] dab_next;
  logic [MW-1:0]   mag_neg;

  assign ctrl       = itoa_fmt_pkg::ucode(pc_q);
  assign in_ready_o = (ctrl.op == itoa_fmt_pkg::OP_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign blocked    = out_valid_q && !out_ready_i;

  // Mask the operand to the configured width and find its sign
  assign operand = MW'(in_data_i.value) & MASK;
  assign in_hex  = (in_data_i.mode == itoa_fmt_pkg::MODE_HEXL) ||
                   (in_data_i.mode == itoa_fmt_pkg::MODE_HEXU);
  assign in_neg  = (in_data_i.mode == itoa_fmt_pkg::MODE_SDEC) && operand[VALUE_WIDTH-1];
  assign mag_neg = (~operand + 1'b1) & MASK;

  assign top_digit  = dr_q[DR_W-1 -: 4];
  assign last_digit = (rem_q == RW'(1));

  // Status flags for the sequencer
  always_comb begin
    flags.no_input  = !in_valid_i;
    flags.loop      = (cnt_q != '0);
    flags.hex       = in_hex;
    flags.lead_zero = (top_digit == 4'd0) && !last_digit;
    flags.sign_wait = neg_q && blocked;
    flags.emit_more = blocked || !last_digit;
  end

  // Step counter: hold, branch or advance
  always_comb begin
    if (itoa_fmt_pkg::cond_true(ctrl.hold, flags)) begin
      pc_d = pc_q;
    end else if (itoa_fmt_pkg::cond_true(ctrl.jump, flags)) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + 3'd1;
    end
  end

  // Four double-dabble iterations per cycle
  always_comb begin
    logic [DR_W-1:0] t;
    t = dr_q;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < NDIG; j++) begin
        if (t[4*j +: 4] >= 4'd5) begin
          t[4*j +: 4] = t[4*j +: 4] + 4'd3;
        end
      end
      t = {t[DR_W-2:0], mag_q[MW-1-k]};
    end
    dab_next = t;
  end

  // Datapath driven by the current control word
  always_comb begin
    mag_d        = mag_q;
    dr_d         = dr_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    neg_d        = neg_q;
    hex_d        = hex_q;
    upper_d      = upper_q;
    out_d        = out_q;
    char_total_d = char_total_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (ctrl.op)
      itoa_fmt_pkg::OP_LOAD: begin
        if (in_fire) begin
          mag_d   = in_neg ? mag_neg : operand;
          dr_d    = in_hex ? DR_W'(operand) : '0;
          cnt_d   = CW'(DAB_STEPS - 1);
          rem_d   = RW'(NDIG);
          neg_d   = in_neg;
          hex_d   = in_hex;
          upper_d = (in_data_i.mode == itoa_fmt_pkg::MODE_HEXU);
        end
      end
      itoa_fmt_pkg::OP_DABBLE: begin
        dr_d  = dab_next;
        mag_d = mag_q << 4;
        cnt_d = cnt_q - 1'b1;
      end
      itoa_fmt_pkg::OP_SKIP: begin
        if (flags.lead_zero) begin
          dr_d  = dr_q << 4;
          rem_d = rem_q - 1'b1;
        end
      end
      itoa_fmt_pkg::OP_SIGN: begin
        if (neg_q && !blocked) begin
          out_valid_d = 1'b1;
          out_d.out_char  = itoa_fmt_pkg::CHAR_MINUS;
          out_d.last_char = 1'b0;
          if (char_total_q != itoa_fmt_pkg::COUNT_MAX) begin
            char_total_d = char_total_q + 1'b1;
          end
          out_d.total_chars = char_total_d;
        end
      end
      itoa_fmt_pkg::OP_EMIT: begin
        if (!blocked) begin
          out_valid_d = 1'b1;
          out_d.out_char  = itoa_fmt_pkg::digit_char(top_digit, upper_q);
          out_d.last_char = last_digit;
          if (char_total_q != itoa_fmt_pkg::COUNT_MAX) begin
            char_total_d = char_total_q + 1'b1;
          end
          out_d.total_chars = char_total_d;
          dr_d  = dr_q << 4;
          rem_d = rem_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= itoa_fmt_pkg::ST_LOAD;
      out_valid_q  <= 1'b0;
      char_total_q <= '0;
    end else begin
      pc_q         <= pc_d;
      out_valid_q  <= out_valid_d;
      char_total_q <= char_total_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    dr_q    <= dr_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    hex_q   <= hex_d;
    upper_q <= upper_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pc_q == itoa_fmt_pkg::ST_SKIP) || (pc_q == itoa_fmt_pkg::ST_EMIT)) |-> (rem_q != '0))
    else $error("digit count ran out while skipping or sending");

  a_dec_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pc_q == itoa_fmt_pkg::ST_EMIT) && !hex_q) |-> (top_digit <= 4'd9))
    else $error("decimal digit out of range");

  a_leave_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pc_q != itoa_fmt_pkg::ST_LOAD))
    else $error("sequencer stayed on load after taking a transaction");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_total_q >= $past(char_total_q)))
    else $error("character count went backwards");

endmodule
